// File: rtl/tdpt_pkg.sv
// Shared types and constants of the trial-division prime tester.
package tdpt_pkg;

  localparam int unsigned CandWidth       = 16;
  localparam int unsigned CountWidth      = 16;
  localparam int unsigned ValueWidthDflt  = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_EVAL,
    S_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // capture a new candidate, restart at divisor 3
    logic div_start;   // clear the remainder and load the dividend shifter
    logic div_step;    // one restoring-division bit
    logic next_div;    // advance to the next odd divisor
    logic verdict_we;  // write the verdict register
    logic verdict;     // value for the verdict register
    logic emit;        // move the verdict and count into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic below_two; // candidate below two
    logic even;      // candidate is even
    logic is_two;    // candidate equals two
    logic sq_gt;     // divisor squared exceeds the candidate
    logic rem_zero;  // remainder of the finished division is zero
    logic div_last;  // the current division step is the last one
    logic out_busy;  // output register holds an item not taken this cycle
  } status_t;

endpackage

// File: rtl/tdpt_cand_if.sv
// Candidate channel: valid/ready with one candidate number per item.
interface tdpt_cand_if;
  logic                                 valid;
  logic                                 ready;
  logic [tdpt_pkg::CandWidth-1:0]       candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

// File: rtl/tdpt_res_if.sv
// Result channel: valid/ready with the verdict and the running prime count.
interface tdpt_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 is_prime;
  logic [tdpt_pkg::CountWidth-1:0]      prime_count;

  modport source (output valid, output is_prime, output prime_count, input ready);
  modport sink   (input valid, input is_prime, input prime_count, output ready);
endinterface

// File: rtl/trial_division_prime_test_top.sv
// Top level of the trial-division prime tester: controller, datapath, checks.
//
//   channel   dir  handshake      payload
//   cand_i    in   valid/ready    candidate[15:0]
//   res_o     out  valid/ready    is_prime, prime_count[15:0]
//
// One item at a time. An item that is below two, even, or below nine is settled
// by the first check; otherwise each odd divisor is tried in turn (3, 5, 7, ...
// while divisor squared stays within the candidate) by the bit-serial divider,
// one quotient bit a cycle: a 16-bit prime near 65535 tries 127 divisors.
// Reset clears the controller, the output valid flag and the prime count.
// A result waits in the output register; the next item is accepted meanwhile
// and the block stalls at its end only while the previous result is not taken.
module trial_division_prime_test_top #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::ValueWidthDflt
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tdpt_cand_if.sink    cand_i,
  tdpt_res_if.source   res_o
);

  tdpt_pkg::cmd_t    cmd;
  tdpt_pkg::status_t status;

  // Sequence the candidate checks and the per-divisor divisions.
  tdpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cand_i.valid),
    .in_ready_o (cand_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the candidate, divisor, remainder and the output register.
  tdpt_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cand_i        (cand_i.candidate),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .is_prime_o    (res_o.is_prime),
    .prime_count_o (res_o.prime_count)
  );

  // An accepted item keeps the block busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cand_i.valid && cand_i.ready) |=> !cand_i.ready)
    else $error("input ready right after an accepted item");

  // Never overwrite a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(res_o.valid && !res_o.ready))
    else $error("result overwritten while stalled");

  // A prime result always carries a nonzero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.is_prime) |-> (res_o.prime_count != '0))
    else $error("prime reported with zero count");

  // An emitted item shows up as a valid result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> res_o.valid)
    else $error("emitted item not presented");

endmodule

// File: rtl/tdpt_ctrl.sv
// Sequencing state machine of the trial-division prime tester.
module tdpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tdpt_pkg::status_t status_i,
  output tdpt_pkg::cmd_t    cmd_o
);

  tdpt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdpt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      tdpt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tdpt_pkg::S_CHECK;
        end
      end
      tdpt_pkg::S_CHECK: begin
        if (status_i.below_two) begin
          cmd_o.verdict_we = 1'b1;
          cmd_o.verdict    = 1'b0;
          state_d          = tdpt_pkg::S_DONE;
        end else if (status_i.even) begin
          cmd_o.verdict_we = 1'b1;
          cmd_o.verdict    = status_i.is_two;
          state_d          = tdpt_pkg::S_DONE;
        end else if (status_i.sq_gt) begin
          cmd_o.verdict_we = 1'b1;
          cmd_o.verdict    = 1'b1;
          state_d          = tdpt_pkg::S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = tdpt_pkg::S_DIV;
        end
      end
      tdpt_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = tdpt_pkg::S_EVAL;
        end
      end
      tdpt_pkg::S_EVAL: begin
        if (status_i.rem_zero) begin
          cmd_o.verdict_we = 1'b1;
          cmd_o.verdict    = 1'b0;
          state_d          = tdpt_pkg::S_DONE;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = tdpt_pkg::S_CHECK;
        end
      end
      tdpt_pkg::S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = tdpt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tdpt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/tdpt_dpath.sv
// Datapath: candidate, odd divisor and its square, bit-serial divider, output register.
module tdpt_dpath #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::ValueWidthDflt
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [tdpt_pkg::CandWidth-1:0]    cand_i,
  input  tdpt_pkg::cmd_t                    cmd_i,
  output tdpt_pkg::status_t                 status_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              is_prime_o,
  output logic [tdpt_pkg::CountWidth-1:0]   prime_count_o
);

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned IdxW = $clog2(VALUE_WIDTH);

  logic [31+tdpt_pkg::CandWidth:0] cand_ext;
  logic [W-1:0]   n_q, d_q, rem_q, shift_q;
  logic [W+1:0]   sq_q;
  logic [IdxW-1:0] cnt_q;
  logic [W:0]     trial;
  logic [W-1:0]   rem_d;
  logic           verdict_q;
  logic           out_valid_q, is_prime_q;
  logic [tdpt_pkg::CountWidth-1:0] count_q;

  // Bits of the candidate above VALUE_WIDTH are dropped.
  assign cand_ext = {32'd0, cand_i};

  // Restoring division: shift in one dividend bit, subtract when it fits.
  assign trial = {rem_q, shift_q[W-1]};
  always_comb begin
    if (trial >= {1'b0, d_q}) begin
      rem_d = W'(trial - {1'b0, d_q});
    end else begin
      rem_d = trial[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q  <= cand_ext[W-1:0];
      d_q  <= W'(3);
      sq_q <= (W+2)'(9);
    end else if (cmd_i.next_div) begin
      d_q  <= d_q + W'(2);
      sq_q <= sq_q + {d_q, 2'b00} + (W+2)'(4);
    end
    if (cmd_i.div_start) begin
      rem_q   <= '0;
      shift_q <= n_q;
      cnt_q   <= IdxW'(W - 1);
    end else if (cmd_i.div_step) begin
      rem_q   <= rem_d;
      shift_q <= {shift_q[W-2:0], 1'b0};
      cnt_q   <= cnt_q - IdxW'(1);
    end
    if (cmd_i.verdict_we) begin
      verdict_q <= cmd_i.verdict;
    end
    if (cmd_i.emit) begin
      is_prime_q <= verdict_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (verdict_q && (count_q != '1)) begin
          count_q <= count_q + tdpt_pkg::CountWidth'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.below_two = (n_q[W-1:1] == '0);
  assign status_o.even      = ~n_q[0];
  assign status_o.is_two    = (n_q == W'(2));
  assign status_o.sq_gt     = (sq_q > {2'b00, n_q});
  assign status_o.rem_zero  = (rem_q == '0);
  assign status_o.div_last  = (cnt_q == '0);
  assign status_o.out_busy  = out_valid_q & ~out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign is_prime_o    = is_prime_q;
  assign prime_count_o = count_q;

endmodule

// File: tb/sv/tdpt_result_checker.sv
// Checker for the prime tester: predicts each verdict and compares it with the result channel.
module tdpt_result_checker
  import tdpt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDflt
) (
  input  logic clk_i,
  input  logic rst_ni,
  tdpt_cand_if cand,
  tdpt_res_if  res,
  output int   fail_count,
  output int   results_pending
);

  typedef struct packed {
    logic                  is_prime;
    logic [CountWidth-1:0] prime_count;
  } verdict_t;

  verdict_t              verdict_q[$];
  logic [CountWidth-1:0] primes_seen;
  int                    mismatches = 0;
  int                    pending    = 0;

  assign fail_count      = mismatches;
  assign results_pending = pending;

  // Trial division by odd divisors up to the square root.
  function automatic logic is_prime_number(logic [CandWidth-1:0] value);
    longint unsigned n;
    longint unsigned d;
    n = value & ((64'd1 << VALUE_WIDTH) - 64'd1);
    if (n < 2) return 1'b0;
    if (n % 2 == 0) return n == 2;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t              want;
    verdict_t              got;
    logic [CountWidth-1:0] count_next;
    if (!rst_ni) begin
      primes_seen <= '0;
    end else begin
      // Retire the oldest verdict first, so a result never matches an item taken this cycle.
      if (res.valid && res.ready) begin
        got.is_prime    = res.is_prime;
        got.prime_count = res.prime_count;
        if (verdict_q.size() == 0) begin
          $error("unexpected result: is_prime %0d, prime_count %0d",
                 got.is_prime, got.prime_count);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (got.is_prime !== want.is_prime) begin
            $error("is_prime mismatch: expected %0d, actual %0d", want.is_prime, got.is_prime);
            mismatches++;
          end
          if (got.prime_count !== want.prime_count) begin
            $error("prime_count mismatch: expected %0d, actual %0d",
                   want.prime_count, got.prime_count);
            mismatches++;
          end
        end
      end
      if (cand.valid && cand.ready) begin
        want.is_prime = is_prime_number(cand.candidate);
        count_next    = primes_seen;
        if (want.is_prime && count_next != '1) count_next++;
        want.prime_count = count_next;
        primes_seen <= count_next;
        verdict_q.push_back(want);
      end
      pending = verdict_q.size();
    end
  end

endmodule

// File: tb/sv/tb_trial_division_prime_test_top.sv
// Testbench top for the prime tester: clock, reset, candidate stimulus and verdict.
module tb_trial_division_prime_test_top;
  import tdpt_pkg::*;

  // This limit leaves plenty of room for the slowest items and for stalls.
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  // Cycles to hold after the last result, in case a stray one follows.
  localparam int unsigned SETTLE_CYCLES = 64;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   results_pending;
  int   sender_idle_pct;
  int   receiver_idle_pct;
  logic cand_took;
  int unsigned cycle_count = 0;

  tdpt_cand_if cand ();
  tdpt_res_if  res ();

  trial_division_prime_test_top u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cand_i (cand),
    .res_o  (res)
  );

  tdpt_result_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cand            (cand),
    .res             (res),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // Corner candidates: zero and one, the only even prime, small odd primes and
  // odd squares from nine up, the largest 16-bit prime, the square of a
  // large prime (full divisor sweep, then a hit), and the all-ones value.
  logic [CandWidth-1:0] corner_candidates [20] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd8, 16'd9, 16'd11,
    16'd25, 16'd49, 16'd97, 16'd169, 16'd32768, 16'd63001, 16'd65025,
    16'd65521, 16'd65535, 16'd1
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Remember whether the last rising edge moved a candidate, for the driver at the falling edge.
  always @(posedge clk) begin
    cand_took <= cand.valid && cand.ready;
  end

  // Drop ready at random per the current receiver idle rate.
  initial res.ready = 1'b0;
  always @(negedge clk) begin
    res.ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_trial_division_prime_test_top NOT OK");
      $finish;
    end
  end

  // Mostly small values keep items short; a share of full-range and large odd
  // values exercises every bit and the long divisor sweeps.
  function automatic logic [CandWidth-1:0] pick_candidate();
    int unsigned          roll;
    logic [CandWidth-1:0] value;
    roll = $urandom_range(99);
    if (roll < 15) value = CandWidth'($urandom_range(255));
    else if (roll < 65) value = CandWidth'($urandom_range(1023));
    else if (roll < 90) value = CandWidth'($urandom);
    else value = CandWidth'($urandom_range(65535, 32768)) | 16'd1;
    return value;
  endfunction

  // Enter and leave at a falling edge; hold the item until it is taken.
  task automatic send_candidate(input logic [CandWidth-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      cand.valid <= 1'b0;
      @(negedge clk);
    end
    cand.valid     <= 1'b1;
    cand.candidate <= value;
    do @(negedge clk); while (!cand_took);
  endtask

  // Lower valid and wait until every predicted verdict has come back.
  task automatic drain_results();
    cand.valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
  endtask

  initial begin
    cand.valid        = 1'b0;
    cand.candidate    = '0;
    rst_n             = 1'b0;
    sender_idle_pct   = 25;
    receiver_idle_pct = 71;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed corners, then the first random phase: sender mostly busy, receiver mostly stalled.
    foreach (corner_candidates[i]) send_candidate(corner_candidates[i]);
    repeat (40) send_candidate(pick_candidate());

    // Swap the idle rates; halfway through, hold off until the block has emptied.
    sender_idle_pct   = 71;
    receiver_idle_pct = 25;
    repeat (20) send_candidate(pick_candidate());
    drain_results();
    repeat (20) send_candidate(pick_candidate());

    // No idling on either side.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    repeat (36) send_candidate(pick_candidate());

    // Close with a long prime sweep and short items back to back.
    send_candidate(16'd65521);
    send_candidate(16'd3);
    send_candidate(16'd4);
    send_candidate(16'd1);

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_trial_division_prime_test_top OK");
    end else begin
      $display("tb_trial_division_prime_test_top NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tdpt_pkg.sv
rtl/tdpt_cand_if.sv
rtl/tdpt_res_if.sv
rtl/tdpt_ctrl.sv
rtl/tdpt_dpath.sv
rtl/trial_division_prime_test_top.sv
tb/sv/tdpt_result_checker.sv
tb/sv/tb_trial_division_prime_test_top.sv
